// File: hdl/bmp_rle_decoder_top_defines.svh
// ---------------------------------------------------------------------------
// BMP RLE decoder assertion macros
// Shared concurrent assertion forms used by the parser core.
// ---------------------------------------------------------------------------
`ifndef BMP_RLE_DECODER_TOP_DEFINES_SVH
`define BMP_RLE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define BMPRLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BMPRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/bmprle_pkg.sv
// ---------------------------------------------------------------------------
// BMP RLE decoder package
// Payload types, parser phases and fixed constants of the decoder.
// ---------------------------------------------------------------------------
package bmprle_pkg;

    localparam int POS_W = 13;
    localparam int ROW_OUT_W = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [POS_W-1:0] POS_MAX = 13'h1fff;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_MODE = 2'd2;

    // Escape codes that follow a zero count byte.
    localparam logic [7:0] ESC_END_OF_LINE = 8'h00;
    localparam logic [7:0] ESC_END_OF_BITMAP = 8'h01;
    localparam logic [7:0] ESC_DELTA = 8'h02;

    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_END = 1'b1;

    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_VALUE = 3'd1,
        PH_ESC   = 3'd2,
        PH_DX    = 3'd3,
        PH_DY    = 3'd4,
        PH_ABS   = 3'd5,
        PH_PAD   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       picture_start;
    } t_in_item;

    typedef struct packed {
        logic                 item_kind;
        logic [POS_W-1:0]     start_column;
        logic [ROW_OUT_W-1:0] target_row;
        logic [7:0]           run_length;
        logic [7:0]           even_pixel;
        logic [7:0]           odd_pixel;
        logic                 out_of_range;
    } t_out_item;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] image_width;
        logic [CFG_DATA_W-1:0] image_height;
        logic                  nibble_mode;
    } t_cfg;

endpackage

// File: hdl/bmprle_in_stage.sv
// ---------------------------------------------------------------------------
// BMP RLE input stage
// Registers one accepted byte and hands it to the parser.
// ---------------------------------------------------------------------------
module bmprle_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  bmprle_pkg::t_in_item  i_item,
    input  logic                  i_advance,
    output logic                  o_valid,
    output bmprle_pkg::t_in_item  o_item
);
    import bmprle_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    // The stage can take a new byte when empty or when its byte moves on.
    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item = r_item;

endmodule

// File: hdl/bmprle_core.sv
// ---------------------------------------------------------------------------
// BMP RLE parser core
// Parse state, position tracking and run item generation for one byte.
// ---------------------------------------------------------------------------
module bmprle_core #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  bmprle_pkg::t_in_item  i_item,
    input  bmprle_pkg::t_cfg      i_cfg,
    output logic                  o_res_valid,
    output bmprle_pkg::t_out_item o_res
);
    import bmprle_pkg::*;

    `include "bmp_rle_decoder_top_defines.svh"

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int CMP_W = (DIM_W > POS_W + 1) ? DIM_W : POS_W + 1;
    localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIMENSION);
    localparam logic [CMP_W-1:0] POS_MAX_X = CMP_W'(POS_MAX);

    t_phase           r_phase, n_phase, e_phase;
    logic [7:0]       r_pending, n_pending, e_pending;
    logic [7:0]       r_abs_left, n_abs_left, e_abs_left;
    logic [POS_W-1:0] r_col, n_col, e_col;
    logic [POS_W-1:0] r_row, n_row, e_row;
    logic             r_done, n_done, e_done;

    logic [CMP_W-1:0] w_dim, h_dim;
    logic [CMP_W-1:0] row_sum, col_sum, run_sum;
    logic [7:0]       code;
    logic [3:0]       hi_nib, lo_nib;
    logic             run_req, end_req, pad;
    logic [7:0]       run_len, run_even, run_odd;

    function automatic logic [CMP_W-1:0] eff_dim(input logic [CFG_DATA_W-1:0] v);
        logic [CMP_W-1:0] x;
        x = CMP_W'(v);
        if (x == '0) begin
            return CMP_W'(1);
        end else if (x > DIM_MAX) begin
            return DIM_MAX;
        end
        return x;
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic [CMP_W-1:0] s);
        return (s > POS_MAX_X) ? POS_MAX : s[POS_W-1:0];
    endfunction

    assign w_dim = eff_dim(i_cfg.image_width);
    assign h_dim = eff_dim(i_cfg.image_height);
    assign code = i_item.code_byte;
    assign hi_nib = code[7:4];
    assign lo_nib = code[3:0];

    always_comb begin
        // A picture start clears the position and parser before the byte.
        e_phase = r_phase;
        e_pending = r_pending;
        e_abs_left = r_abs_left;
        e_col = r_col;
        e_row = r_row;
        e_done = r_done;
        if (i_item.picture_start) begin
            e_phase = PH_COUNT;
            e_pending = '0;
            e_abs_left = '0;
            e_col = '0;
            e_row = '0;
            e_done = 1'b0;
        end

        n_phase = e_phase;
        n_pending = e_pending;
        n_abs_left = e_abs_left;
        n_col = e_col;
        n_row = e_row;
        n_done = e_done;
        run_req = 1'b0;
        end_req = 1'b0;
        run_len = '0;
        run_even = '0;
        run_odd = '0;
        pad = 1'b0;
        row_sum = '0;
        col_sum = '0;

        if (!e_done) begin
            unique case (e_phase)
                PH_COUNT: begin
                    if (code != 8'h00) begin
                        n_pending = code;
                        n_phase = PH_VALUE;
                    end else begin
                        n_phase = PH_ESC;
                    end
                end
                PH_VALUE: begin
                    n_phase = PH_COUNT;
                    run_req = 1'b1;
                    run_len = e_pending;
                    if (i_cfg.nibble_mode) begin
                        run_even = {4'h0, hi_nib};
                        run_odd = {4'h0, lo_nib};
                    end else begin
                        run_even = code;
                        run_odd = code;
                    end
                end
                PH_ESC: begin
                    case (code)
                        ESC_END_OF_LINE: begin
                            row_sum = CMP_W'(e_row) + CMP_W'(1);
                            n_col = '0;
                            n_row = sat_pos(row_sum);
                            n_phase = PH_COUNT;
                            end_req = (row_sum >= h_dim);
                        end
                        ESC_END_OF_BITMAP: begin
                            end_req = 1'b1;
                        end
                        ESC_DELTA: begin
                            n_phase = PH_DX;
                        end
                        default: begin
                            n_pending = code;
                            n_abs_left = code;
                            n_phase = PH_ABS;
                        end
                    endcase
                end
                PH_DX: begin
                    col_sum = CMP_W'(e_col) + CMP_W'(code);
                    n_col = sat_pos(col_sum);
                    n_phase = PH_DY;
                end
                PH_DY: begin
                    row_sum = CMP_W'(e_row) + CMP_W'(code);
                    n_row = sat_pos(row_sum);
                    n_phase = PH_COUNT;
                    end_req = (row_sum >= h_dim);
                end
                PH_ABS: begin
                    run_req = 1'b1;
                    if (i_cfg.nibble_mode) begin
                        run_len = (e_abs_left >= 8'd2) ? 8'd2 : 8'd1;
                        run_even = {4'h0, hi_nib};
                        run_odd = {4'h0, lo_nib};
                        pad = (e_pending[1:0] == 2'd1) || (e_pending[1:0] == 2'd2);
                    end else begin
                        run_len = 8'd1;
                        run_even = code;
                        run_odd = code;
                        pad = e_pending[0];
                    end
                    n_abs_left = (e_abs_left > run_len) ? e_abs_left - run_len : 8'd0;
                    if (n_abs_left == 8'd0) begin
                        n_phase = pad ? PH_PAD : PH_COUNT;
                    end
                end
                PH_PAD: begin
                    n_phase = PH_COUNT;
                end
                default: begin
                    n_phase = PH_COUNT;
                end
            endcase
        end

        run_sum = CMP_W'(e_col) + CMP_W'(run_len);
        if (run_req) begin
            n_col = sat_pos(run_sum);
        end
        if (end_req) begin
            n_done = 1'b1;
            n_phase = PH_COUNT;
        end
    end

    // Result item. End items carry zero in every field but the kind.
    always_comb begin
        o_res = '0;
        o_res_valid = run_req || end_req;
        if (end_req) begin
            o_res.item_kind = KIND_END;
        end else begin
            o_res.item_kind = KIND_RUN;
            o_res.start_column = e_col;
            o_res.run_length = run_len;
            o_res.even_pixel = run_even;
            o_res.odd_pixel = run_odd;
            if (CMP_W'(e_row) < h_dim) begin
                o_res.target_row = ROW_OUT_W'(h_dim - CMP_W'(1) - CMP_W'(e_row));
            end
            o_res.out_of_range = (run_sum > w_dim) || (CMP_W'(e_row) >= h_dim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COUNT;
            r_pending <= '0;
            r_abs_left <= '0;
            r_col <= '0;
            r_row <= '0;
            r_done <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pending <= n_pending;
            r_abs_left <= n_abs_left;
            r_col <= n_col;
            r_row <= n_row;
            r_done <= n_done;
        end
    end

    `BMPRLE_ASSERT_NEXT(a_done_sticks, i_clk, i_rst_n,
        r_done && !(i_fire && i_item.picture_start), r_done,
        "done flag cleared without a picture start")
    `BMPRLE_ASSERT_NOW(a_done_silent, i_clk, i_rst_n,
        r_done && !i_item.picture_start, !o_res_valid,
        "result produced after end of picture")
    `BMPRLE_ASSERT_NEXT(a_end_sets_done, i_clk, i_rst_n,
        i_fire && o_res_valid && (o_res.item_kind == KIND_END),
        r_done && (r_phase == PH_COUNT),
        "end item did not close the picture")
    `BMPRLE_ASSERT_NEXT(a_dx_to_dy, i_clk, i_rst_n,
        i_fire && !i_item.picture_start && !r_done && (r_phase == PH_DX),
        r_phase == PH_DY,
        "delta x byte not followed by delta y phase")

endmodule

// File: hdl/bmprle_out_stage.sv
// ---------------------------------------------------------------------------
// BMP RLE output stage
// Holds one result item until the downstream side takes it.
// ---------------------------------------------------------------------------
module bmprle_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  bmprle_pkg::t_out_item i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output bmprle_pkg::t_out_item o_item
);
    import bmprle_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item = r_item;

endmodule

// File: hdl/bmp_rle_decoder_top.sv
// ---------------------------------------------------------------------------
// BMP RLE8 / RLE4 decoder top level
// Byte-wide run-length stream in, pixel run and end-of-picture items out.
// ---------------------------------------------------------------------------
// The decoder takes one compressed byte per clock and returns at most one
// item per byte: a pixel run (start column, bottom-up row, length and two
// alternating palette indices) or one end-of-picture item. A byte is held in
// the input register and parsed, and its result is loaded into the output
// register, from which it leaves the block. A new byte can be transferred in
// every cycle unless stalled, as each byte reads and writes the parser state
// (phase, counts, column and row) once. Transfers stall only while a finished
// result waits in the output register and the downstream side does not take
// it. The user must write width, height and mode on the configuration port
// only while the decoder is idle; the block does not enforce it.
module bmp_rle_decoder_top #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  bmprle_pkg::t_in_item               i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output bmprle_pkg::t_out_item              o_out_item,
    input  logic                               i_cfg_we,
    input  logic [bmprle_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bmprle_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bmprle_pkg::*;

    t_cfg      r_cfg;
    logic      in_valid;
    t_in_item  in_item;
    logic      advance;
    logic      res_valid;
    t_out_item res_item;

    // Configuration registers. Writes land directly; unused indexes are
    // dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width <= CFG_DATA_W'(1);
            r_cfg.image_height <= CFG_DATA_W'(1);
            r_cfg.nibble_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH: r_cfg.image_width <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data;
                CFG_NIBBLE_MODE: r_cfg.nibble_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The registered byte is parsed when the output register is free or is
    // being emptied in the same cycle, so a full pipeline keeps moving.
    assign advance = in_valid && (!o_out_valid || i_out_ready);

    bmprle_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (i_in_item),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    bmprle_core #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_item      (in_item),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res_item)
    );

    bmprle_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_item  (res_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// BMP RLE decoder testbench
// Feeds RLE8 and RLE4 code bytes through the decoder under random stalls on
// both sides and checks every pixel run and end item against a byte-level
// model of the parser kept inside this bench or an item written out by hand.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import bmprle_pkg::*;

    localparam int MAX_DIMENSION = 4096;
    localparam int RANDOM_BYTES = 1150;
    localparam int RANDOM_PHASES = 12;
    localparam int DIRECTED_ROWS = 29;
    localparam int PRINT_LIMIT = 100;

    // A directed row either transfers one byte, transfers one byte whose
    // result is written out by hand, or loads a new set of registers.
    typedef enum logic [1:0] {
        ROW_FEED,
        ROW_TYPED,
        ROW_SETTINGS
    } t_row_kind;

    typedef struct packed {
        t_row_kind       kind;
        t_in_item        stim;
        t_out_item       want;
        logic [12:0]     width_setting;
        logic [12:0]     height_setting;
        logic            nibble_setting;
    } t_table_row;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Bench copy of the decoder registers and parser state.
    logic [12:0] cfg_width = 13'd1;
    logic [12:0] cfg_height = 13'd1;
    logic        cfg_nibble = 1'b0;
    t_phase      parse_state = PH_COUNT;
    logic [7:0]  pending_count = '0;
    logic [7:0]  absolute_left = '0;
    logic [12:0] column_pos = '0;
    logic [12:0] row_pos = '0;
    logic        picture_done = 1'b0;

    // Runs and end items still owed by the decoder, oldest first.
    t_out_item decoded_items[$];

    bit stall_enable = 1'b0;
    bit begin_picture = 1'b0;
    int mismatch_count = 0;
    int useful_bytes = 0;
    int bytes_sent = 0;
    int settings_count = 0;
    int runs_checked = 0;
    int ends_checked = 0;

    t_table_row directed_table [DIRECTED_ROWS];

    bmp_rle_decoder_top #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Byte-level decoder model
    // ------------------------------------------------------------------

    // A zero dimension acts as one, anything above the maximum as the maximum.
    function automatic int clamp_dimension(input logic [12:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_DIMENSION) return MAX_DIMENSION;
        return int'(v);
    endfunction

    function automatic logic [12:0] saturate_pos(input int v);
        return (v > int'(POS_MAX)) ? POS_MAX : 13'(v);
    endfunction

    function automatic t_out_item run_item(input logic [12:0] col, input logic [11:0] row,
                                           input logic [7:0] len, input logic [7:0] ev,
                                           input logic [7:0] od, input logic oor);
        t_out_item r;
        r.item_kind = KIND_RUN;
        r.start_column = col;
        r.target_row = row;
        r.run_length = len;
        r.even_pixel = ev;
        r.odd_pixel = od;
        r.out_of_range = oor;
        return r;
    endfunction

    // An end item carries nothing but its kind.
    function automatic t_out_item end_item();
        t_out_item r;
        r = '0;
        r.item_kind = KIND_END;
        return r;
    endfunction

    function automatic t_out_item finish_picture();
        picture_done = 1'b1;
        parse_state = PH_COUNT;
        return end_item();
    endfunction

    // Places a run at the current position and advances the column. The
    // range flag looks at the unsaturated sum; rows past the image bottom
    // out at output row zero.
    function automatic t_out_item build_run(input int len, input logic [7:0] ev,
                                            input logic [7:0] od);
        int w;
        int h;
        int x;
        int y;
        w = clamp_dimension(cfg_width);
        h = clamp_dimension(cfg_height);
        x = int'(column_pos);
        y = int'(row_pos);
        column_pos = saturate_pos(x + len);
        return run_item(13'(x), (y < h) ? 12'(h - 1 - y) : 12'd0, 8'(len), ev, od,
                        (x + len > w) || (y >= h));
    endfunction

    // Advances the parser by one code byte; returns 1 when the byte
    // completes a run or ends the picture.
    function automatic bit decode_byte(input t_in_item it, output t_out_item item);
        logic [7:0] b;
        logic [7:0] hi_nib;
        logic [7:0] lo_nib;
        int lim_h;
        int next_row;
        int len;
        bit pad;
        b = it.code_byte;
        hi_nib = {4'h0, b[7:4]};
        lo_nib = {4'h0, b[3:0]};
        item = '0;
        if (it.picture_start) begin
            column_pos = '0;
            row_pos = '0;
            picture_done = 1'b0;
            parse_state = PH_COUNT;
            pending_count = '0;
            absolute_left = '0;
        end
        if (picture_done) return 1'b0;
        lim_h = clamp_dimension(cfg_height);
        case (parse_state)
            PH_COUNT: begin
                if (b != 8'd0) begin
                    pending_count = b;
                    parse_state = PH_VALUE;
                end else begin
                    parse_state = PH_ESC;
                end
            end
            PH_VALUE: begin
                parse_state = PH_COUNT;
                if (cfg_nibble) item = build_run(int'(pending_count), hi_nib, lo_nib);
                else item = build_run(int'(pending_count), b, b);
                return 1'b1;
            end
            PH_ESC: begin
                if (b == ESC_END_OF_LINE) begin
                    next_row = int'(row_pos) + 1;
                    column_pos = '0;
                    row_pos = saturate_pos(next_row);
                    parse_state = PH_COUNT;
                    if (next_row >= lim_h) begin
                        item = finish_picture();
                        return 1'b1;
                    end
                end else if (b == ESC_END_OF_BITMAP) begin
                    item = finish_picture();
                    return 1'b1;
                end else if (b == ESC_DELTA) begin
                    parse_state = PH_DX;
                end else begin
                    pending_count = b;
                    absolute_left = b;
                    parse_state = PH_ABS;
                end
            end
            PH_DX: begin
                column_pos = saturate_pos(int'(column_pos) + int'(b));
                parse_state = PH_DY;
            end
            PH_DY: begin
                next_row = int'(row_pos) + int'(b);
                row_pos = saturate_pos(next_row);
                parse_state = PH_COUNT;
                if (next_row >= lim_h) begin
                    item = finish_picture();
                    return 1'b1;
                end
            end
            PH_ABS: begin
                // Padding follows whenever the data bytes used are odd in
                // number, judged by the mode in force at the last data byte.
                if (cfg_nibble) begin
                    len = (absolute_left >= 8'd2) ? 2 : 1;
                    pad = (pending_count[1:0] == 2'd1) || (pending_count[1:0] == 2'd2);
                    item = build_run(len, hi_nib, lo_nib);
                end else begin
                    len = 1;
                    pad = pending_count[0];
                    item = build_run(1, b, b);
                end
                absolute_left = (int'(absolute_left) > len) ? 8'(int'(absolute_left) - len)
                                                             : 8'd0;
                if (absolute_left == 8'd0) parse_state = pad ? PH_PAD : PH_COUNT;
                return 1'b1;
            end
            // The pad byte and any phase without a meaning are dropped.
            default: parse_state = PH_COUNT;
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------

    // Offers one byte, waits for its transfer and books what it should yield.
    task automatic transfer_item(input t_in_item it, input bit typed,
                                 input t_out_item typed_item);
        t_out_item predicted;
        bit live;
        if (stall_enable && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        live = !picture_done || it.picture_start;
        if (decode_byte(it, predicted)) decoded_items.push_back(typed ? typed_item : predicted);
        if (live) useful_bytes++;
        bytes_sent++;
    endtask

    // A pending picture start rides on the next byte; now and then one is
    // thrown in at random to cut a sequence short.
    task automatic push_byte(input logic [7:0] code);
        t_in_item it;
        it.code_byte = code;
        it.picture_start = begin_picture || ($urandom_range(0, 63) == 0);
        begin_picture = 1'b0;
        transfer_item(it, 1'b0, '0);
    endtask

    // Waits until every booked result is out, then waits on for a byte that
    // yields nothing but may still sit in the pipeline.
    task automatic drain_decoder();
        in_valid <= 1'b0;
        while (decoded_items.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic load_settings(input logic [12:0] w, input logic [12:0] h,
                                 input logic nib);
        drain_decoder();
        cfg_we <= 1'b1;
        cfg_idx <= CFG_IMAGE_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_idx <= CFG_IMAGE_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_idx <= CFG_NIBBLE_MODE;
        cfg_data <= CFG_DATA_W'(nib);
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_width = w;
        cfg_height = h;
        cfg_nibble = nib;
        settings_count++;
    endtask

    function automatic t_table_row feed(input logic [7:0] code, input logic start);
        t_table_row r;
        r = '0;
        r.kind = ROW_FEED;
        r.stim.code_byte = code;
        r.stim.picture_start = start;
        return r;
    endfunction

    function automatic t_table_row feed_typed(input logic [7:0] code, input logic start,
                                              input t_out_item want);
        t_table_row r;
        r = feed(code, start);
        r.kind = ROW_TYPED;
        r.want = want;
        return r;
    endfunction

    function automatic t_table_row settings_row(input logic [12:0] w, input logic [12:0] h,
                                                input logic nib);
        t_table_row r;
        r = '0;
        r.kind = ROW_SETTINGS;
        r.width_setting = w;
        r.height_setting = h;
        r.nibble_setting = nib;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report_mismatch(name, int'(got), int'(want));
    endtask

    always @(posedge clk) begin : result_monitor
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (decoded_items.size() == 0) begin
                report_mismatch("item with nothing outstanding", 0, 0);
            end else begin
                want = decoded_items.pop_front();
                check_field("item_kind", 16'(out_item.item_kind), 16'(want.item_kind));
                check_field("start_column", 16'(out_item.start_column),
                            16'(want.start_column));
                check_field("target_row", 16'(out_item.target_row), 16'(want.target_row));
                check_field("run_length", 16'(out_item.run_length), 16'(want.run_length));
                check_field("even_pixel", 16'(out_item.even_pixel), 16'(want.even_pixel));
                check_field("odd_pixel", 16'(out_item.odd_pixel), 16'(want.odd_pixel));
                check_field("out_of_range", 16'(out_item.out_of_range),
                            16'(want.out_of_range));
                if (want.item_kind == KIND_END) ends_checked++;
                else runs_checked++;
            end
        end
    end

    // The receiver alternates between taking every cycle and holding off in
    // bursts; with stalls switched off it simply takes everything.
    initial begin : ready_driver
        int span;
        @(posedge clk);
        forever begin
            span = $urandom_range(1, 16);
            if (stall_enable && $urandom_range(0, 2) == 0) out_ready <= 1'b0;
            else out_ready <= 1'b1;
            repeat (span) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [12:0] w;
        logic [12:0] h;
        int goal;
        int pick;
        int n;
        int data_bytes;

        directed_table = '{
            // Reset settings: one pixel by one row, byte pixels.
            feed(8'h01, 1'b1),
            feed_typed(8'hab, 1'b0, run_item(13'd0, 12'd0, 8'd1, 8'hab, 8'hab, 1'b0)),
            feed(8'h00, 1'b0),
            feed_typed(ESC_END_OF_LINE, 1'b0, end_item()),
            feed(8'h00, 1'b0),
            // Oversized width, full height: the longest run, a far delta,
            // a padded absolute block and end of bitmap.
            settings_row(13'd8191, 13'd4096, 1'b0),
            feed(8'hff, 1'b1),
            feed_typed(8'h00, 1'b0, run_item(13'd0, 12'd4095, 8'd255, 8'h00, 8'h00, 1'b0)),
            feed(8'h00, 1'b0),
            feed(ESC_DELTA, 1'b0),
            feed(8'hff, 1'b0),
            feed(8'hff, 1'b0),
            feed(8'h00, 1'b0),
            feed(8'h03, 1'b0),
            feed(8'h80, 1'b0),
            feed(8'h7f, 1'b0),
            feed(8'h01, 1'b0),
            feed(8'h55, 1'b0),
            feed(8'h00, 1'b0),
            feed_typed(ESC_END_OF_BITMAP, 1'b0, end_item()),
            // Zero dimensions act as one; nibble pixels split each byte.
            settings_row(13'd0, 13'd0, 1'b1),
            feed(8'h04, 1'b1),
            feed_typed(8'ha5, 1'b0, run_item(13'd0, 12'd0, 8'd4, 8'h0a, 8'h05, 1'b1)),
            feed(8'h00, 1'b0),
            feed(8'h03, 1'b0),
            feed(8'hc3, 1'b0),
            feed(8'h96, 1'b0),
            feed(8'h00, 1'b0),
            feed(ESC_END_OF_LINE, 1'b0)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_table[r]) begin
            case (directed_table[r].kind)
                ROW_SETTINGS: load_settings(directed_table[r].width_setting,
                                            directed_table[r].height_setting,
                                            directed_table[r].nibble_setting);
                ROW_TYPED: transfer_item(directed_table[r].stim, 1'b1, directed_table[r].want);
                default: transfer_item(directed_table[r].stim, 1'b0, '0);
            endcase
        end

        // Random phases: each loads new settings, then sends mostly
        // well-formed code sequences with random content. The last phase
        // runs without any stalls.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            stall_enable = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 9))
                0: w = 13'd0;
                1: w = 13'd1;
                2: w = 13'd4096;
                3: w = 13'($urandom_range(4097, 8191));
                default: w = 13'($urandom_range(2, 64));
            endcase
            case ($urandom_range(0, 9))
                0: h = 13'd0;
                1: h = 13'd1;
                2: h = 13'd4096;
                3: h = 13'd8191;
                default: h = 13'($urandom_range(2, 12));
            endcase
            load_settings(w, h, 1'($urandom_range(0, 1)));

            // Sometimes the old picture carries on under the new settings,
            // which can leave the row below a lowered image height.
            begin_picture = ($urandom_range(0, 3) != 0);

            goal = useful_bytes + RANDOM_BYTES / RANDOM_PHASES;

            // Now and then a row of maximum runs drives the column into
            // saturation.
            if ($urandom_range(0, 3) == 0) begin
                repeat (34) begin
                    push_byte(8'hff);
                    push_byte(8'($urandom_range(0, 255)));
                end
            end

            while (useful_bytes < goal) begin
                if (picture_done && $urandom_range(0, 3) != 0) begin_picture = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    // Encoded run: count byte then value byte.
                    n = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(1, 255);
                    push_byte(8'(n));
                    push_byte(8'($urandom_range(0, 255)));
                end else if (pick < 55) begin
                    push_byte(8'h00);
                    push_byte(ESC_END_OF_LINE);
                end else if (pick < 58) begin
                    push_byte(8'h00);
                    push_byte(ESC_END_OF_BITMAP);
                end else if (pick < 68) begin
                    push_byte(8'h00);
                    push_byte(ESC_DELTA);
                    push_byte(8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 8)));
                    push_byte(8'($urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 2)));
                end else if (pick < 90) begin
                    // Absolute block, padded out to a whole word.
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 255)
                                                    : $urandom_range(3, 20);
                    push_byte(8'h00);
                    push_byte(8'(n));
                    data_bytes = cfg_nibble ? (n + 1) / 2 : n;
                    repeat (data_bytes) push_byte(8'($urandom_range(0, 255)));
                    if (data_bytes % 2 != 0) push_byte(8'($urandom_range(0, 255)));
                end else begin
                    push_byte(8'($urandom_range(0, 255)));
                end
            end
        end

        drain_decoder();
        $display("Sent %0d code bytes under %0d register settings in both pixel modes.",
                 bytes_sent, settings_count);
        $display("Checked %0d pixel runs and %0d picture ends.", runs_checked, ends_checked);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Far beyond the slowest legal run with every stall at its longest.
    initial begin : watchdog
        #10_000_000;
        $display("Timed out with %0d results outstanding.", decoded_items.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
